@@ src/ism_pkg.sv @@
`default_nettype none

package ism_pkg;

    // Default geometry
    localparam int STACK_DEPTH_DEF = 16;
    localparam int PC_BITS_DEF     = 16;

    // Fixed field widths
    localparam int FUNC_W     = 8;
    localparam int WORD_W     = 32;
    localparam int NPC_W      = 16;
    localparam int LEN_W      = 16;
    localparam int FAULT_W    = 3;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Instruction lengths in bytes: opcode alone, or opcode plus 4-byte immediate
    localparam int IMM_BYTES      = 4;
    localparam int INSN_SHORT_LEN = 1;
    localparam int INSN_LONG_LEN  = INSN_SHORT_LEN + IMM_BYTES;

    // Register map
    localparam logic [APB_ADDR_W-1:0] REG_PROG_LEN_ADDR = 3'd0;

    // Opcodes
    localparam logic [FUNC_W-1:0] OP_PUSH     = 8'h01;
    localparam logic [FUNC_W-1:0] OP_PUSH_STR = 8'h02;
    localparam logic [FUNC_W-1:0] OP_PRINT    = 8'h03;
    localparam logic [FUNC_W-1:0] OP_INPUT    = 8'h04;
    localparam logic [FUNC_W-1:0] OP_ADD      = 8'h05;
    localparam logic [FUNC_W-1:0] OP_SUB      = 8'h06;
    localparam logic [FUNC_W-1:0] OP_MUL      = 8'h07;
    localparam logic [FUNC_W-1:0] OP_CMP      = 8'h08;
    localparam logic [FUNC_W-1:0] OP_JE       = 8'h09;
    localparam logic [FUNC_W-1:0] OP_JNE      = 8'h0A;
    localparam logic [FUNC_W-1:0] OP_JMP      = 8'h0B;
    localparam logic [FUNC_W-1:0] OP_CALLBACK = 8'h0C;

    // Fault codes
    localparam logic [FAULT_W-1:0] FLT_NONE    = 3'd0;
    localparam logic [FAULT_W-1:0] FLT_INVALID = 3'd1;
    localparam logic [FAULT_W-1:0] FLT_UNDER   = 3'd2;
    localparam logic [FAULT_W-1:0] FLT_OVER    = 3'd3;
    localparam logic [FAULT_W-1:0] FLT_STRING  = 3'd4;

    // Stack operations: combine pops two entries and pushes one
    typedef enum logic [1:0] {
        STK_HOLD,
        STK_PUSH,
        STK_POP,
        STK_COMBINE
    } stk_op_t;

    typedef struct packed {
        stk_op_t             op;
        logic [WORD_W-1:0]   data;
    } stk_ctl_t;

    typedef struct packed {
        logic [NPC_W-1:0]    next_pc;
        logic                print_valid;
        logic [WORD_W-1:0]   print_value;
        logic                halted;
        logic [FAULT_W-1:0]  fault_code;
    } ism_res_t;

endpackage

`default_nettype wire

@@ src/ism_stack.sv @@
`default_nettype none

module ism_stack
    import ism_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire stk_ctl_t           ctl,
    output logic [WORD_W-1:0]       top,
    output logic [WORD_W-1:0]       second,
    output logic [CNT_W-1:0]        count
);

    logic [WORD_W-1:0] entry_reg [DEPTH];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    // Shift the entries: entry 0 is the top of the stack
    always_ff @(posedge clk)
    begin
        unique case (ctl.op)
            STK_PUSH:
            begin
                entry_reg[0] <= ctl.data;
                for (int i = 1; i < DEPTH; i++)
                begin
                    entry_reg[i] <= entry_reg[i-1];
                end
            end
            STK_POP:
            begin
                for (int i = 0; i < DEPTH - 1; i++)
                begin
                    entry_reg[i] <= entry_reg[i+1];
                end
            end
            STK_COMBINE:
            begin
                entry_reg[0] <= ctl.data;
                for (int i = 1; i < DEPTH - 1; i++)
                begin
                    entry_reg[i] <= entry_reg[i+1];
                end
            end
            STK_HOLD:
            begin
            end
        endcase
    end

    // Track the fill level
    always_comb
    begin
        unique case (ctl.op)
            STK_PUSH:    count_next = count_reg + CNT_W'(1);
            STK_POP:     count_next = count_reg - CNT_W'(1);
            STK_COMBINE: count_next = count_reg - CNT_W'(1);
            STK_HOLD:    count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign top    = entry_reg[0];
    assign second = entry_reg[1];
    assign count  = count_reg;

endmodule

`default_nettype wire

@@ src/ism_exec.sv @@
`default_nettype none

module ism_exec
    import ism_pkg::*;
#(
    parameter int PC_BITS = PC_BITS_DEF,
    parameter int DEPTH   = STACK_DEPTH_DEF,
    parameter int CNT_W   = $clog2(DEPTH + 1)
)
(
    input  wire logic [FUNC_W-1:0]  func,
    input  wire logic [WORD_W-1:0]  immediate,
    input  wire logic [WORD_W-1:0]  console_value,
    input  wire logic [PC_BITS-1:0] pc,
    input  wire logic [LEN_W-1:0]   program_length,
    input  wire logic [CNT_W-1:0]   count,
    input  wire logic [WORD_W-1:0]  top,
    input  wire logic [WORD_W-1:0]  second,
    output logic [PC_BITS-1:0]      npc,
    output stk_ctl_t                ctl,
    output ism_res_t                res
);

    localparam int CMP_W = (PC_BITS > LEN_W) ? PC_BITS : LEN_W;

    logic [CMP_W-1:0]   pc_ext;
    logic [CMP_W-1:0]   npc_ext;
    logic [CMP_W-1:0]   len_ext;
    logic [PC_BITS-1:0] pc_short;
    logic [PC_BITS-1:0] pc_long;
    logic [PC_BITS-1:0] target;
    logic               at_end;
    logic               empty;
    logic               full;
    logic               has_two;
    logic [WORD_W-1:0]  arith;
    logic [FAULT_W-1:0] fault;
    logic               pv;
    logic [WORD_W-1:0]  pval;

    assign pc_ext   = CMP_W'(pc);
    assign len_ext  = CMP_W'(program_length);
    assign at_end   = pc_ext >= len_ext;
    assign pc_short = pc + PC_BITS'(INSN_SHORT_LEN);
    assign pc_long  = pc + PC_BITS'(INSN_LONG_LEN);
    assign target   = immediate[PC_BITS-1:0];
    assign empty    = count == '0;
    assign full     = count >= CNT_W'(DEPTH);
    assign has_two  = count >= CNT_W'(2);

    // Two-operand result from the top and the entry below it; SUB and CMP give second minus top
    always_comb
    begin
        unique case (func)
            OP_ADD:  arith = top + second;
            OP_MUL:  arith = top * second;
            default: arith = second - top;
        endcase
    end

    // Decode and execute one instruction
    always_comb
    begin
        npc      = pc_short;
        ctl.op   = STK_HOLD;
        ctl.data = arith;
        fault    = FLT_NONE;
        pv       = 1'b0;
        pval     = '0;
        if (at_end)
        begin
            npc = pc;
        end
        else
        begin
            unique case (func)
                OP_PUSH:
                begin
                    npc = pc_long;
                    if (full)
                    begin
                        fault = FLT_OVER;
                    end
                    else
                    begin
                        ctl.op   = STK_PUSH;
                        ctl.data = immediate;
                    end
                end
                OP_PRINT:
                begin
                    if (!empty)
                    begin
                        ctl.op = STK_POP;
                        pv     = 1'b1;
                        pval   = top;
                    end
                end
                OP_INPUT:
                begin
                    if (!empty)
                    begin
                        if (full)
                        begin
                            fault = FLT_OVER;
                        end
                        else
                        begin
                            ctl.op   = STK_PUSH;
                            ctl.data = console_value;
                        end
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_CMP:
                begin
                    if (!has_two)
                    begin
                        fault = FLT_UNDER;
                    end
                    else
                    begin
                        ctl.op = STK_COMBINE;
                    end
                end
                OP_JE, OP_JNE:
                begin
                    npc = pc_long;
                    if (empty)
                    begin
                        fault = FLT_UNDER;
                    end
                    else
                    begin
                        ctl.op = STK_POP;
                        if ((func == OP_JE) == (top == '0))
                        begin
                            npc = target;
                        end
                    end
                end
                OP_JMP:
                begin
                    npc = target;
                end
                OP_PUSH_STR, OP_CALLBACK:
                begin
                    fault = FLT_STRING;
                end
                default:
                begin
                    fault = FLT_INVALID;
                end
            endcase
        end
    end

    assign npc_ext = CMP_W'(npc);

    // Pack the result
    always_comb
    begin
        res.next_pc     = NPC_W'(npc);
        res.print_valid = pv;
        res.print_value = pval;
        res.fault_code  = fault;
        res.halted      = at_end || (fault != FLT_NONE) || (npc_ext >= len_ext);
    end

endmodule

`default_nettype wire

@@ src/integer_stack_machine_execute.sv @@
// An input transfer passes the input register, then the result register, to its result transfer.
// Throughput: one instruction per cycle unless a result stalls; stack and PC update on execute.
// A stalled result holds both stages; the input register still takes one transfer while empty.
// Reset (rst_n low, asynchronous) clears the PC, stack count, program_length and valid flags.
// Stack contents are not cleared; only entries below the count are ever read.
`default_nettype none

module integer_stack_machine_execute
    import ism_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int PC_BITS     = PC_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_W-1:0]    paddr,
    input  wire logic [APB_DATA_W-1:0]    pwdata,
    output logic [APB_DATA_W-1:0]         prdata,
    output logic                          pready,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [FUNC_W-1:0]        func,
    input  wire logic signed [WORD_W-1:0] immediate,
    input  wire logic signed [WORD_W-1:0] console_value,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [NPC_W-1:0]              next_pc,
    output logic                          print_valid,
    output logic signed [WORD_W-1:0]      print_value,
    output logic                          halted,
    output logic [FAULT_W-1:0]            fault_code
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    logic [LEN_W-1:0]   prog_len_reg;
    logic [PC_BITS-1:0] pc_reg;
    logic               in_valid_reg;
    logic [FUNC_W-1:0]  func_reg;
    logic [WORD_W-1:0]  imm_reg;
    logic [WORD_W-1:0]  con_reg;
    logic               out_valid_reg;
    ism_res_t           res_reg;

    logic               advance;
    logic               exec_fire;
    logic               cfg_write;
    logic [PC_BITS-1:0] npc;
    stk_ctl_t           exec_ctl;
    stk_ctl_t           stk_ctl;
    ism_res_t           exec_res;
    logic [WORD_W-1:0]  top;
    logic [WORD_W-1:0]  second;
    logic [CNT_W-1:0]   count;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == REG_PROG_LEN_ADDR);
    assign prdata    = (paddr == REG_PROG_LEN_ADDR) ? APB_DATA_W'(prog_len_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_len_reg <= '0;
        end
        else if (cfg_write)
        begin
            prog_len_reg <= pwdata[LEN_W-1:0];
        end
    end

    // Handshake: the result stage frees when empty or taken
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || advance;
    assign exec_fire = in_valid_reg && advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg <= func;
            imm_reg  <= immediate;
            con_reg  <= console_value;
        end
    end

    ism_exec #(
        .PC_BITS (PC_BITS),
        .DEPTH   (STACK_DEPTH),
        .CNT_W   (CNT_W)
    ) u_exec (
        .func           (func_reg),
        .immediate      (imm_reg),
        .console_value  (con_reg),
        .pc             (pc_reg),
        .program_length (prog_len_reg),
        .count          (count),
        .top            (top),
        .second         (second),
        .npc            (npc),
        .ctl            (exec_ctl),
        .res            (exec_res)
    );

    // Apply stack changes only when the instruction executes
    always_comb
    begin
        stk_ctl = exec_ctl;
        if (!exec_fire)
        begin
            stk_ctl.op = STK_HOLD;
        end
    end

    ism_stack #(
        .DEPTH (STACK_DEPTH),
        .CNT_W (CNT_W)
    ) u_stack (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (stk_ctl),
        .top    (top),
        .second (second),
        .count  (count)
    );

    // Advance the PC
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
        end
        else if (exec_fire)
        begin
            pc_reg <= npc;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            res_reg <= exec_res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign next_pc     = res_reg.next_pc;
    assign print_valid = res_reg.print_valid;
    assign print_value = res_reg.print_value;
    assign halted      = res_reg.halted;
    assign fault_code  = res_reg.fault_code;

endmodule

`default_nettype wire

@@ src/ism_checker.sv @@
`default_nettype none

module ism_checker
    import ism_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     out_valid,
    input  wire logic                     out_ready,
    input  wire logic [NPC_W-1:0]         next_pc,
    input  wire logic                     print_valid,
    input  wire logic signed [WORD_W-1:0] print_value,
    input  wire logic                     halted,
    input  wire logic [FAULT_W-1:0]       fault_code
);

    // Hold a stalled result transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(next_pc)
            && $stable(print_value) && $stable(fault_code) && $stable(halted))
    else $error("stalled result changed");

    // Any fault stops execution
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (fault_code != FLT_NONE) |-> halted)
    else $error("fault without halt");

    // A print only completes without a fault
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && print_valid |-> fault_code == FLT_NONE)
    else $error("print together with fault");

    // Without a print, the print value is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !print_valid |-> print_value == '0)
    else $error("print value without print");

endmodule

bind integer_stack_machine_execute ism_checker u_ism_checker (.*);

`default_nettype wire
